/* hdl/scene_cut_detector_defines.svh */
// Assertion macros shared by the scene cut detector RTL.
// Depends on nothing; the checks compile away when SYNTHESIS is defined.
`ifndef SCENE_CUT_DETECTOR_DEFINES_SVH
`define SCENE_CUT_DETECTOR_DEFINES_SVH
`ifndef SYNTHESIS
`define SCD_ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SCD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define SCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SCD_ASSERT_HOLDS(lbl, clk, rst_n, prop, msg)
`define SCD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define SCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hdl/scd_pkg.sv */
// Shared widths, register indexes, reset values and types of the scene cut detector.
// Depends on nothing; the interfaces, the top level and the store all import it.
package scd_pkg;

  localparam int THUMB_WIDTH_DEF  = 64;
  localparam int THUMB_HEIGHT_DEF = 36;

  localparam int PIXEL_W    = 8;
  localparam int TIME_W     = 32;
  localparam int SUM_W      = 20;
  localparam int INTERVAL_W = 8;
  localparam int GAP_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP_MS     = 2'd2;

  localparam logic [INTERVAL_W-1:0] PROBE_INTERVAL_RST = 8'd15;
  localparam logic [SUM_W-1:0]      DIFF_THRESHOLD_RST = 20'd58752;
  localparam logic [GAP_W-1:0]      MIN_GAP_MS_RST     = 16'd2000;

  localparam logic [PIXEL_W-1:0] STORE_INIT = 8'd128;
  localparam logic [SUM_W-1:0]   SUM_MAX    = 20'hFFFFF;

  typedef struct packed {
    logic en;
    logic wr;
  } store_req_t;

endpackage

/* hdl/scd_ifs.sv */
// Valid/ready channel interfaces for pixel words, result words and register writes.
// Depends on scd_pkg for the field widths.
interface scd_in_if;
  import scd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [PIXEL_W-1:0]       pixel;
  logic [TIME_W-1:0]        frame_time_ms;
  modport source (output valid, output pixel, output frame_time_ms, input ready);
  modport sink   (input valid, input pixel, input frame_time_ms, output ready);
endinterface

interface scd_out_if;
  import scd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     picked;
  logic [SUM_W-1:0]         diff_sum;
  logic [TIME_W-1:0]        out_time_ms;
  modport source (output valid, output picked, output diff_sum, output out_time_ms,
                  input ready);
  modport sink   (input valid, input picked, input diff_sum, input out_time_ms,
                  output ready);
endinterface

interface scd_cfg_if;
  import scd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_W-1:0]     index;
  logic [CFG_DATA_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/scene_cut_detector.sv */
// Scene cut detector top level: frame sampling, difference sum and pick decision.
// Depends on scd_pkg, scd_ifs, scd_thumb_store and scene_cut_detector_defines.svh.
//
//   channel  | dir | word
//   ---------+-----+---------------------------------------------
//   in_ch    | in  | pixel, frame_time_ms
//   out_ch   | out | picked, diff_sum, out_time_ms (last pixel of examined frame)
//   cfg_ch   | in  | index, data (always ready)
//
// One pixel word is accepted per cycle while in_ch is not stalled; the store read and
// the index update are registered in the first stage, and the difference and pick
// decision in the second, which ends in the output register that holds the result.
// Reset is synchronous; the store needs no clearing pass, since entries read as 128
// until the first examined frame has been written through.
// in_ch stalls only while a finished result waits in the output register and the
// next word to finish is another result.
`include "scene_cut_detector_defines.svh"

module scene_cut_detector #(
  parameter int THUMB_WIDTH  = scd_pkg::THUMB_WIDTH_DEF,
  parameter int THUMB_HEIGHT = scd_pkg::THUMB_HEIGHT_DEF
) (
  input logic       clk,
  input logic       rst_n,
  scd_in_if.sink    in_ch,
  scd_out_if.source out_ch,
  scd_cfg_if.sink   cfg_ch
);
  import scd_pkg::*;

  localparam int PIX_COUNT = THUMB_WIDTH * THUMB_HEIGHT;
  localparam int POS_W     = $clog2(PIX_COUNT);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(PIX_COUNT - 1);

  logic [INTERVAL_W-1:0] probe_r;
  logic [SUM_W-1:0]      thresh_r;
  logic [GAP_W-1:0]      gap_r;

  logic [POS_W-1:0]      pos_r;
  logic [INTERVAL_W-1:0] phase_r;
  logic                  filled_r;

  logic                  s1_v_r;
  logic [PIXEL_W-1:0]    s1_px_r;
  logic [TIME_W-1:0]     s1_time_r;
  logic                  s1_exam_r;
  logic                  s1_last_r;
  logic                  s1_fill_r;
  logic [PIXEL_W-1:0]    rd_data;

  logic [SUM_W-1:0]      acc_r;
  logic                  await_r;
  logic [TIME_W-1:0]     last_pick_r;

  logic                  out_v_r;
  logic                  picked_r;
  logic [SUM_W-1:0]      sum_r;
  logic [TIME_W-1:0]     time_r;

  logic                  accept;
  logic                  examined;
  logic                  is_last;
  logic [INTERVAL_W-1:0] interval;
  logic [INTERVAL_W:0]   phase_inc;
  logic [INTERVAL_W-1:0] phase_nxt;
  store_req_t            store_req;

  logic                  s1_emit;
  logic                  s1_go;
  logic                  s1_take;
  logic [PIXEL_W-1:0]    old_px;
  logic [PIXEL_W-1:0]    abs_diff;
  logic [SUM_W:0]        acc_sum;
  logic [SUM_W-1:0]      acc_nxt;
  logic [TIME_W:0]       gap_limit;
  logic                  pick;

  // Register writes.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r  <= PROBE_INTERVAL_RST;
      thresh_r <= DIFF_THRESHOLD_RST;
      gap_r    <= MIN_GAP_MS_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_PROBE_INTERVAL: probe_r  <= cfg_ch.data[INTERVAL_W-1:0];
        CFG_DIFF_THRESHOLD: thresh_r <= cfg_ch.data[SUM_W-1:0];
        CFG_MIN_GAP_MS:     gap_r    <= cfg_ch.data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Front stage: pixel index, frame phase and store access.
  assign accept    = in_ch.valid && in_ch.ready;
  assign examined  = (phase_r == '0);
  assign is_last   = (pos_r == LAST_POS);
  assign interval  = (probe_r == '0) ? INTERVAL_W'(1) : probe_r;
  assign phase_inc = {1'b0, phase_r} + (INTERVAL_W+1)'(1);
  assign phase_nxt = (phase_inc >= {1'b0, interval}) ? '0 : phase_inc[INTERVAL_W-1:0];

  assign store_req.en = accept;
  assign store_req.wr = accept && examined;

  scd_thumb_store #(
    .DEPTH (PIX_COUNT),
    .AW    (POS_W)
  ) u_store (
    .clk     (clk),
    .req     (store_req),
    .addr    (pos_r),
    .wdata   (in_ch.pixel),
    .rdata_r (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      phase_r  <= '0;
      filled_r <= 1'b0;
    end else if (accept) begin
      if (is_last) begin
        pos_r   <= '0;
        phase_r <= phase_nxt;
        if (examined) begin
          filled_r <= 1'b1;
        end
      end else begin
        pos_r <= pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r   <= in_ch.pixel;
      s1_time_r <= in_ch.frame_time_ms;
      s1_exam_r <= examined;
      s1_last_r <= is_last;
      s1_fill_r <= filled_r;
    end
  end

  // Second stage: difference, accumulation and pick decision.
  assign s1_emit  = s1_exam_r && s1_last_r;
  assign s1_go    = !(s1_emit && out_v_r && !out_ch.ready);
  assign s1_take  = s1_v_r && s1_go;
  assign in_ch.ready = !s1_v_r || s1_go;

  assign old_px    = s1_fill_r ? rd_data : STORE_INIT;
  assign abs_diff  = (s1_px_r >= old_px) ? (s1_px_r - old_px) : (old_px - s1_px_r);
  assign acc_sum   = {1'b0, acc_r} + (SUM_W+1)'(abs_diff);
  assign acc_nxt   = acc_sum[SUM_W] ? SUM_MAX : acc_sum[SUM_W-1:0];
  assign gap_limit = {1'b0, last_pick_r} + (TIME_W+1)'(gap_r);
  assign pick      = await_r ||
                     ((acc_nxt >= thresh_r) && ({1'b0, s1_time_r} >= gap_limit));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      acc_r       <= '0;
      await_r     <= 1'b1;
      last_pick_r <= '0;
    end else begin
      s1_v_r <= accept || (s1_v_r && !s1_go);
      if (s1_take) begin
        if (s1_last_r) begin
          acc_r <= '0;
        end else if (s1_exam_r) begin
          acc_r <= acc_nxt;
        end
        if (s1_emit && pick) begin
          await_r     <= 1'b0;
          last_pick_r <= s1_time_r;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_take && s1_emit) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && s1_emit) begin
      picked_r <= pick;
      sum_r    <= acc_nxt;
      time_r   <= s1_time_r;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.picked      = picked_r;
  assign out_ch.diff_sum    = sum_r;
  assign out_ch.out_time_ms = time_r;

  `SCD_ASSERT_HOLDS(a_pos_range, clk, rst_n, pos_r <= LAST_POS, "pixel index out of range")
  `SCD_ASSERT_NEXT(a_result_loaded, clk, rst_n, s1_take && s1_emit, out_v_r, "result not loaded")
  `SCD_ASSERT_NEXT(a_pick_clears, clk, rst_n, s1_take && s1_emit && pick, !await_r,
                   "first pick kept")
  `SCD_ASSERT_IMPL(a_stall_cause, clk, rst_n, !in_ch.ready,
                   s1_v_r && out_v_r && !out_ch.ready, "input stalled without cause")
  `SCD_ASSERT_IMPL(a_skip_no_write, clk, rst_n, store_req.wr, phase_r == '0,
                   "store written in skipped frame")

endmodule

/* hdl/scd_thumb_store.sv */
// Single-port thumbnail memory with read-first behavior and a registered read.
// Depends on scd_pkg for the request struct and pixel width.
module scd_thumb_store #(
  parameter int DEPTH = 2304,
  parameter int AW    = 12
) (
  input  logic                       clk,
  input  scd_pkg::store_req_t        req,
  input  logic [AW-1:0]              addr,
  input  logic [scd_pkg::PIXEL_W-1:0] wdata,
  output logic [scd_pkg::PIXEL_W-1:0] rdata_r
);
  import scd_pkg::*;

  logic [PIXEL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.en) begin
      rdata_r <= mem[addr];
      if (req.wr) begin
        mem[addr] <= wdata;
      end
    end
  end

endmodule
